// ----- hdl/cpr_pkg.sv -----
// Shared constants and controller/datapath interface types for the clock page replacer.
package cpr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 20;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 5;
  localparam int SLOT_W    = 4;
  localparam int FAULT_W   = 32;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = CFG_W'(16);

  typedef struct packed {
    logic load;
    logic hit_take;
    logic norm_hand;
    logic sweep_step;
    logic replace;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic ref_at_hand;
  } sts_t;

endpackage

// ----- hdl/clock_page_replacement.sv -----
// Top level of the clock (second-chance) page replacer.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  command  | start / busy               | page_number_i
//  result   | done_o (one-cycle strobe)  | hit_o slot_o evicted_valid_o
//           |                            | evicted_page_o fault_total_o
//  config   | cfg_valid_i / cfg_ready_o  | cfg_data_i (frame count)
//
// A hit passes through the lookup state alone and strobes its word in the next cycle.
// A miss passes through the lookup state and then the sweep state: the hand sweeps
// one frame per cycle over the effective frame count until it finds a clear reference bit.
// A new command may be accepted in the cycle the previous result is strobed.
// Reset clears valid and reference bits, hand and fault count; frame count goes to 16.
// The receiver cannot stall: each result word is valid for exactly one cycle.
module clock_page_replacement
  import cpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]   fault_total_o
);

  cmd_t cmd;
  sts_t sts;

  cpr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cpr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .page_number_i   (page_number_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

endmodule

// ----- hdl/cpr_ctrl.sv -----
// Controller state machine: lookup, hand sweep and result issue sequencing.
module cpr_ctrl
  import cpr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts_i.hit) begin
          cmd_o.hit_take = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.norm_hand = 1'b1;
          state_d         = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (!sts_i.ref_at_hand) begin
          cmd_o.replace = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.sweep_step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  a_look_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK |-> $past(start && state_q == S_IDLE))
    else $error("lookup entered without an accepted word");

  a_sweep_after_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && $past(state_q) != S_SWEEP) |-> $past(state_q == S_LOOK && !sts_i.hit))
    else $error("sweep entered without a miss");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.hit_take, cmd_o.norm_hand, cmd_o.sweep_step, cmd_o.replace}))
    else $error("more than one datapath command issued");

endmodule

// ----- hdl/cpr_datapath.sv -----
// Datapath: frame tags, valid and reference bits, hand, fault counter and result registers.
module cpr_datapath
  import cpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]   fault_total_o
);

  logic [PAGE_BITS-1:0] pages_q [FRAMES];
  logic [FRAMES-1:0]    valid_q;
  logic [FRAMES-1:0]    ref_q;
  logic [IDX_W-1:0]     hand_q;
  logic [FAULT_W-1:0]   fault_q;
  logic [CFG_W-1:0]     fc_q;
  logic                 done_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 hit_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 ev_valid_q;
  logic [PAGE_BITS-1:0] ev_page_q;

  logic [CNT_W-1:0]     n_eff;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic [CNT_W-1:0]     hand_nx;
  logic [IDX_W-1:0]     hand_wrap;

  always_comb begin
    if (fc_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(fc_q) > 32'(FRAMES)) begin
      n_eff = CNT_W'(FRAMES);
    end else begin
      n_eff = CNT_W'(fc_q);
    end
  end

  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (valid_q[i] && (CNT_W'(i) < n_eff) && (pages_q[i] == page_q)) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
    end
  end

  assign hand_nx   = CNT_W'(hand_q) + CNT_W'(1);
  assign hand_wrap = (hand_nx >= n_eff) ? '0 : IDX_W'(hand_nx);

  assign sts_o.hit         = hit_found;
  assign sts_o.ref_at_hand = ref_q[hand_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ref_q   <= '0;
      hand_q  <= '0;
      fault_q <= '0;
      fc_q    <= FRAME_COUNT_RST;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.hit_take | cmd_i.replace;
      if (cfg_valid_i) begin
        fc_q <= cfg_data_i;
      end
      if (cmd_i.hit_take) begin
        ref_q[hit_idx] <= 1'b1;
      end
      if (cmd_i.norm_hand && (CNT_W'(hand_q) >= n_eff)) begin
        hand_q <= '0;
      end
      if (cmd_i.sweep_step) begin
        ref_q[hand_q] <= 1'b0;
        hand_q        <= hand_wrap;
      end
      if (cmd_i.replace) begin
        valid_q[hand_q] <= 1'b1;
        ref_q[hand_q]   <= 1'b1;
        hand_q          <= hand_wrap;
        if (fault_q != '1) begin
          fault_q <= fault_q + FAULT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= page_number_i;
    end
    if (cmd_i.hit_take) begin
      hit_q      <= 1'b1;
      slot_q     <= SLOT_W'(hit_idx);
      ev_valid_q <= 1'b0;
      ev_page_q  <= '0;
    end
    if (cmd_i.replace) begin
      pages_q[hand_q] <= page_q;
      hit_q           <= 1'b0;
      slot_q          <= SLOT_W'(hand_q);
      ev_valid_q      <= valid_q[hand_q];
      ev_page_q       <= valid_q[hand_q] ? pages_q[hand_q] : '0;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_total_o   = fault_q;

  a_fault_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q != $past(fault_q) |-> fault_q == $past(fault_q) + FAULT_W'(1))
    else $error("fault counter moved by other than one");

  a_sweep_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_step |=> !ref_q[$past(hand_q)])
    else $error("sweep step left reference bit set");

  a_replace_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.replace |=> valid_q[$past(hand_q)] && ref_q[$past(hand_q)] && done_o && !hit_o)
    else $error("replaced frame not marked valid and referenced");

endmodule

// ----- tb/clock_page_replacement_checker.sv -----
// Checker for the clock page replacer: predicts every result word and compares it on arrival.
module clock_page_replacement_checker
  import cpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 done_i,
  input  logic                 hit_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic                 evicted_valid_i,
  input  logic [PAGE_BITS-1:0] evicted_page_i,
  input  logic [FAULT_W-1:0]   fault_total_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   hits_o,
  output int                   evictions_o
);

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    logic [FAULT_W-1:0]   faults;
  } page_word_t;

  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic                 frame_used [FRAMES];
  logic                 ref_bit    [FRAMES];
  int                   hand;
  logic [FAULT_W-1:0]   faults;
  logic [CFG_W-1:0]     frame_count;
  page_word_t           resident_q [$];

  function automatic int frames_in_use();
    if (frame_count == '0) return 1;
    if (int'(frame_count) > FRAMES) return FRAMES;
    return int'(frame_count);
  endfunction

  function automatic page_word_t reference_page(input logic [PAGE_BITS-1:0] pg);
    page_word_t w;
    int         n;
    int         victim;
    bit         found;
    w = '0;
    found = 1'b0;
    n = frames_in_use();
    for (int i = 0; i < n; i++) begin
      if (!found && frame_used[i] && frame_page[i] == pg) begin
        found = 1'b1;
        ref_bit[i] = 1'b1;
        w.hit = 1'b1;
        w.slot = SLOT_W'(i);
      end
    end
    if (!found) begin
      if (hand >= n) hand = 0;
      victim = hand;
      for (int s = 0; s <= 2 * n && !found; s++) begin
        if (!ref_bit[hand]) begin
          victim = hand;
          found = 1'b1;
        end else begin
          ref_bit[hand] = 1'b0;
          hand = (hand + 1 >= n) ? 0 : hand + 1;
          victim = hand;
        end
      end
      w.slot = SLOT_W'(victim);
      if (frame_used[victim]) begin
        w.ev_valid = 1'b1;
        w.ev_page = frame_page[victim];
      end
      frame_page[victim] = pg;
      frame_used[victim] = 1'b1;
      ref_bit[victim] = 1'b1;
      hand = (victim + 1 >= n) ? 0 : victim + 1;
      if (faults != '1) faults = faults + FAULT_W'(1);
    end
    w.faults = faults;
    return w;
  endfunction

  task automatic check_field(input string what, input logic [FAULT_W-1:0] want,
                             input logic [FAULT_W-1:0] got);
    if (got !== want) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    page_word_t want;
    if (!rst_ni) begin
      for (int k = 0; k < FRAMES; k++) begin
        frame_page[k] = '0;
        frame_used[k] = 1'b0;
        ref_bit[k] = 1'b0;
      end
      hand = 0;
      faults = '0;
      frame_count = FRAME_COUNT_RST;
      resident_q.delete();
      errors_o = 0;
      pending_o = 0;
      hits_o = 0;
      evictions_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) frame_count = cfg_data_i;
      if (done_i === 1'b1) begin
        if (resident_q.size() == 0) begin
          errors_o++;
          $display("%0t: result word with none expected, expected nothing, actual hit=%0b slot=%0h",
                   $time, hit_i, slot_i);
        end else begin
          want = resident_q.pop_front();
          check_field("hit", FAULT_W'(want.hit), FAULT_W'(hit_i));
          check_field("slot", FAULT_W'(want.slot), FAULT_W'(slot_i));
          check_field("evicted_valid", FAULT_W'(want.ev_valid), FAULT_W'(evicted_valid_i));
          check_field("evicted_page", FAULT_W'(want.ev_page), FAULT_W'(evicted_page_i));
          check_field("fault_total", want.faults, fault_total_i);
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        want = reference_page(page_i);
        resident_q.push_back(want);
        if (want.hit) hits_o++;
        if (want.ev_valid) evictions_o++;
      end
      pending_o = resident_q.size();
    end
  end

endmodule

// ----- tb/clock_page_replacement_tb.sv -----
// Testbench top for the clock page replacer: drives page references and frame counts.
module clock_page_replacement_tb;
  import cpr_pkg::*;

  localparam int PHASES          = 13;
  localparam int REFS_PER_PHASE  = 100;
  localparam int SETTLE_CYCLES   = 40;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [PAGE_BITS-1:0] page_number_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 done_o;
  logic                 hit_o;
  logic [SLOT_W-1:0]    slot_o;
  logic                 evicted_valid_o;
  logic [PAGE_BITS-1:0] evicted_page_o;
  logic [FAULT_W-1:0]   fault_total_o;

  int errors;
  int pending;
  int hits;
  int evictions;
  int refs_sent;
  int count_writes;

  clock_page_replacement dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .page_number_i   (page_number_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

  clock_page_replacement_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .page_i          (page_number_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .done_i          (done_o),
    .hit_i           (hit_o),
    .slot_i          (slot_o),
    .evicted_valid_i (evicted_valid_o),
    .evicted_page_i  (evicted_page_o),
    .fault_total_i   (fault_total_o),
    .errors_o        (errors),
    .pending_o       (pending),
    .hits_o          (hits),
    .evictions_o     (evictions)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_page(input logic [PAGE_BITS-1:0] pg, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    page_number_i <= pg;
    do @(posedge clk_i); while (busy !== 1'b0);
    refs_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] n);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= n;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    count_writes++;
  endtask

  initial begin
    logic [CFG_W-1:0]     sweep_counts [9];
    logic [PAGE_BITS-1:0] pool [$];
    logic [PAGE_BITS-1:0] pg;
    logic [CFG_W-1:0]     cnt;
    int                   eff;
    int                   r;
    bit                   steady;

    rst_ni = 1'b0;
    start = 1'b0;
    page_number_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    refs_sent = 0;
    count_writes = 0;
    sweep_counts = '{5'd31, 5'd0, 5'd1, 5'd16, 5'd17, 5'd4, 5'd2, 5'd9, 5'd3};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill empty frames at reset size, then hit both extremes
    send_page('0, pick_gap());
    send_page('1, pick_gap());
    send_page('0, pick_gap());
    send_page('1, pick_gap());
    // two frames, both referenced: full sweep evicts frame zero
    write_frames(5'd2);
    send_page(20'h12345, pick_gap());
    send_page('1, pick_gap());
    // one frame hides frame one, so the same page lands twice
    write_frames(5'd1);
    send_page('1, pick_gap());
    send_page('1, pick_gap());
    write_frames(5'd16);
    send_page('1, pick_gap());
    send_page(20'hABCDE, pick_gap());
    write_frames(5'd0);
    send_page(20'h00001, pick_gap());
    send_page(20'h80000, pick_gap());
    send_page(20'h00001, pick_gap());
    write_frames(5'd31);
    send_page(20'h55555, pick_gap());
    send_page(20'hAAAAA, pick_gap());
    send_page('1, pick_gap());
    send_page(20'h55555, 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 9) cnt = sweep_counts[phase];
      else if ($urandom_range(0, 3) == 0) cnt = CFG_W'($urandom_range(17, 31));
      else cnt = CFG_W'($urandom_range(0, 16));
      write_frames(cnt);
      eff = (cnt == '0) ? 1 : ((int'(cnt) > FRAMES) ? FRAMES : int'(cnt));
      pool.delete();
      repeat ($urandom_range(1, 2 * eff + 3)) pool.push_back(PAGE_BITS'($urandom));
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < REFS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 85) pg = pool[$urandom_range(0, pool.size() - 1)];
        else if (r < 90) pg = r[0] ? '1 : '0;
        else pg = PAGE_BITS'($urandom);
        if (k == REFS_PER_PHASE / 2 && phase[0]) drain();
        send_page(pg, steady ? 0 : pick_gap());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Covered %0d page references over %0d frame-count writes (0, 1, 16 and 17..31 included).",
             refs_sent, count_writes);
    $display("Predicted %0d hits and %0d evictions; %0d words still outstanding.",
             hits, evictions, pending);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/cpr_pkg.sv
hdl/cpr_ctrl.sv
hdl/cpr_datapath.sv
hdl/clock_page_replacement.sv
tb/clock_page_replacement_checker.sv
tb/clock_page_replacement_tb.sv
